[hdl/pbe_pkg.sv]
// Package for the Phong BRDF evaluate unit: widths, constants, register indexes.
// No dependencies.
package pbe_pkg;

    localparam int EXP_BITS_DEF = 10;
    localparam int COL_W        = 17;
    localparam int SHIN_W       = 10;
    localparam int VEC_W        = 16;
    localparam int OUT_W        = 24;
    localparam int Q16_W        = 17;   // Q0.16 with room for 1.0
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 17;

    localparam logic [Q16_W-1:0] ONE_Q16     = 17'd65536;
    localparam logic [30:0]      INV_PI_Q32  = 31'd1367130551;
    localparam logic [29:0]      INV_2PI_Q32 = 30'd683565276;
    localparam logic [OUT_W-1:0] OUT_MAX     = 24'hFFFFFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KD_R  = 3'd0,
        REG_KD_G  = 3'd1,
        REG_KD_B  = 3'd2,
        REG_KS_R  = 3'd3,
        REG_KS_G  = 3'd4,
        REG_KS_B  = 3'd5,
        REG_SHIN  = 3'd6,
        REG_NONE  = 3'd7
    } cfg_reg_t;

    // Rounded Q0.16 product; both operands at most 1.0, so 17 bits suffice.
    function automatic logic [Q16_W-1:0] qmul16(input logic [Q16_W-1:0] x,
                                                input logic [Q16_W-1:0] y);
        logic [2*Q16_W-1:0] prod;
        prod = x * y + 34'd32768;
        return prod[Q16_W+15:16];
    endfunction

endpackage

[hdl/pbe_pow_cell.sv]
// One square-and-multiply step of the power chain.
// Depends on pbe_pkg.
module pbe_pow_cell (
    input  logic                        aclk,
    input  logic                        en,
    input  logic                        exp_bit,
    input  logic [pbe_pkg::Q16_W-1:0]   p_in,
    input  logic [pbe_pkg::Q16_W-1:0]   base_in,
    output logic [pbe_pkg::Q16_W-1:0]   p_out,
    output logic [pbe_pkg::Q16_W-1:0]   base_out
);

    logic [pbe_pkg::Q16_W-1:0] p_reg, base_reg, p_next, base_next;

    always_comb begin
        p_next    = exp_bit ? pbe_pkg::qmul16(p_in, base_in) : p_in;
        base_next = pbe_pkg::qmul16(base_in, base_in);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p_reg    <= p_next;
            base_reg <= base_next;
        end
    end

    assign p_out    = p_reg;
    assign base_out = base_reg;

endmodule

[hdl/pbe_channel.sv]
// Per-color output stage: specular scale, constant multiplies, sum, saturate.
// Three register stages. Depends on pbe_pkg.
module pbe_channel #(
    parameter int EXP_BITS = pbe_pkg::EXP_BITS_DEF
) (
    input  logic                        aclk,
    input  logic [2:0]                  en,
    input  logic [pbe_pkg::COL_W-1:0]   kd,
    input  logic [pbe_pkg::COL_W-1:0]   ks,
    input  logic [EXP_BITS-1:0]         nexp,
    input  logic [pbe_pkg::Q16_W-1:0]   p,
    output logic [pbe_pkg::OUT_W-1:0]   refl
);

    localparam int NW = EXP_BITS + 1;
    localparam int KN_W = pbe_pkg::COL_W + NW;
    localparam int T_W = KN_W + pbe_pkg::Q16_W;
    localparam int T16_W = T_W - 16;

    logic [KN_W-1:0]   kn_reg, kn_next;
    logic [pbe_pkg::Q16_W-1:0] p_reg;
    logic [pbe_pkg::COL_W-1:0] kd1_reg, kd2_reg;
    logic [T16_W-1:0]  t16_reg, t16_next;
    logic [T_W-1:0]    t_full;
    logic [T16_W+30:0] spec_reg, spec_next;
    logic [47:0]       diff_reg, diff_next;
    logic [T16_W+31:0] sum;
    logic [T16_W-1:0]  r;

    always_comb begin
        kn_next   = KN_W'(ks * ({1'b0, nexp} + NW'(2)));
        t_full    = kn_reg * p_reg + T_W'(32768);
        t16_next  = t_full[T_W-1:16];
        spec_next = t16_reg * pbe_pkg::INV_2PI_Q32;
        diff_next = 48'(kd2_reg * pbe_pkg::INV_PI_Q32);
        sum       = (T16_W+32)'(spec_reg) + (T16_W+32)'(diff_reg) + (T16_W+32)'(33'h80000000);
        r         = sum[T16_W+31:32];
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            kn_reg  <= kn_next;
            p_reg   <= p;
            kd1_reg <= kd;
        end
        if (en[1]) begin
            t16_reg <= t16_next;
            kd2_reg <= kd1_reg;
        end
        if (en[2]) begin
            spec_reg <= spec_next;
            diff_reg <= diff_next;
        end
    end

    assign refl = (r > T16_W'(pbe_pkg::OUT_MAX)) ? pbe_pkg::OUT_MAX
                                                 : r[pbe_pkg::OUT_W-1:0];

endmodule

[hdl/phong_brdf_evaluate_unit.sv]
// Top level of the Phong BRDF evaluate unit: config registers, cosine front end,
// power cell chain and color stages. Depends on pbe_pkg, pbe_pow_cell, pbe_channel.
//
//  channel | ports                       | direction
//  cfg     | cfg_valid/ready, index/data | in
//  s_      | s_valid/ready, 9 components | in
//  m_      | m_valid/ready, 3 colors     | out
//
// One request per cycle while the output is not stalled. The pipe holds four cosine
// stages, one power cell per exponent bit, three color stages and an output register.
// The whole pipe advances when the output register is empty or taken, so a
// stall on m_ready holds every stage. Reset clears the valid bits, kd and ks.
module phong_brdf_evaluate_unit #(
    parameter int EXP_BITS = pbe_pkg::EXP_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [pbe_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pbe_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [15:0]            s_light_x,
    input  logic signed [15:0]            s_light_y,
    input  logic signed [15:0]            s_light_z,
    input  logic signed [15:0]            s_view_x,
    input  logic signed [15:0]            s_view_y,
    input  logic signed [15:0]            s_view_z,
    input  logic signed [15:0]            s_surf_nx,
    input  logic signed [15:0]            s_surf_ny,
    input  logic signed [15:0]            s_surf_nz,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [pbe_pkg::OUT_W-1:0]     m_refl_red,
    output logic [pbe_pkg::OUT_W-1:0]     m_refl_green,
    output logic [pbe_pkg::OUT_W-1:0]     m_refl_blue
);

    localparam int FE = 4;
    localparam int CH = 3;
    localparam int DEPTH = FE + EXP_BITS + CH;
    localparam int Q = pbe_pkg::Q16_W;

    logic [pbe_pkg::COL_W-1:0] kd_reg [3];
    logic [pbe_pkg::COL_W-1:0] ks_reg [3];
    logic [pbe_pkg::SHIN_W-1:0] shin_reg;
    logic [EXP_BITS-1:0] nexp;

    logic [DEPTH-1:0] vld_reg, vld_next;
    logic adv;
    logic out_vld_reg;

    // config
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 3; i++) begin
                kd_reg[i] <= '0;
                ks_reg[i] <= '0;
            end
            shin_reg <= pbe_pkg::SHIN_W'(1);
        end else if (cfg_valid) begin
            case (pbe_pkg::cfg_reg_t'(cfg_index))
                pbe_pkg::REG_KD_R: kd_reg[0] <= cfg_data;
                pbe_pkg::REG_KD_G: kd_reg[1] <= cfg_data;
                pbe_pkg::REG_KD_B: kd_reg[2] <= cfg_data;
                pbe_pkg::REG_KS_R: ks_reg[0] <= cfg_data;
                pbe_pkg::REG_KS_G: ks_reg[1] <= cfg_data;
                pbe_pkg::REG_KS_B: ks_reg[2] <= cfg_data;
                pbe_pkg::REG_SHIN: shin_reg <= cfg_data[pbe_pkg::SHIN_W-1:0];
                default: ;
            endcase
        end
    end

    generate
        if (EXP_BITS >= pbe_pkg::SHIN_W) begin : g_nw
            assign nexp = EXP_BITS'(shin_reg);
        end else begin : g_nn
            assign nexp = shin_reg[EXP_BITS-1:0];
        end
    endgenerate

    // handshake: whole pipe moves together
    assign adv     = !out_vld_reg || m_ready;
    assign s_ready = adv;
    assign m_valid = out_vld_reg;

    always_comb vld_next = {vld_reg[DEPTH-2:0], s_valid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= '0;
            out_vld_reg <= 1'b0;
        end else if (adv) begin
            vld_reg     <= vld_next;
            out_vld_reg <= vld_reg[DEPTH-1];
        end
    end

    // front end stage 1: nine products
    logic signed [31:0] pa_reg [3], pd_reg [3], pe_reg [3];
    always_ff @(posedge aclk) begin
        if (adv) begin
            pa_reg[0] <= s_light_x * s_view_x;
            pa_reg[1] <= s_light_y * s_view_y;
            pa_reg[2] <= s_light_z * s_view_z;
            pd_reg[0] <= s_light_x * s_surf_nx;
            pd_reg[1] <= s_light_y * s_surf_ny;
            pd_reg[2] <= s_light_z * s_surf_nz;
            pe_reg[0] <= s_surf_nx * s_view_x;
            pe_reg[1] <= s_surf_ny * s_view_y;
            pe_reg[2] <= s_surf_nz * s_view_z;
        end
    end

    // stage 2: sums, round D
    logic signed [33:0] a_reg, e_reg, d_sum;
    logic signed [19:0] d14_reg;
    always_comb d_sum = 34'(pd_reg[0]) + 34'(pd_reg[1]) + 34'(pd_reg[2]) + 34'sd8192;
    always_ff @(posedge aclk) begin
        if (adv) begin
            a_reg   <= 34'(pa_reg[0]) + 34'(pa_reg[1]) + 34'(pa_reg[2]);
            e_reg   <= 34'(pe_reg[0]) + 34'(pe_reg[1]) + 34'(pe_reg[2]);
            d14_reg <= d_sum[33:14];
        end
    end

    // stage 3: 2*D14*E
    logic signed [55:0] de_reg;
    logic signed [47:0] a14_reg;
    always_ff @(posedge aclk) begin
        if (adv) begin
            de_reg  <= 56'(d14_reg * e_reg) <<< 1;
            a14_reg <= 48'(a_reg) <<< 14;
        end
    end

    // stage 4: cosine, clamp, round
    logic signed [56:0] c42;
    logic [30:0] c_rnd;
    logic [Q-1:0] c_reg;
    always_comb begin
        c42   = 57'(a14_reg) - 57'(de_reg);
        c_rnd = 31'((c42[55:0] + 56'(1 << 25)) >> 26);
    end
    always_ff @(posedge aclk) begin
        if (adv) begin
            if (c42 <= 0) c_reg <= '0;
            else if (c_rnd > 31'(pbe_pkg::ONE_Q16)) c_reg <= pbe_pkg::ONE_Q16;
            else c_reg <= c_rnd[Q-1:0];
        end
    end

    // power chain
    logic [Q-1:0] p_w [EXP_BITS+1];
    logic [Q-1:0] b_w [EXP_BITS+1];
    assign p_w[0] = pbe_pkg::ONE_Q16;
    assign b_w[0] = c_reg;
    genvar g;
    generate
        for (g = 0; g < EXP_BITS; g++) begin : g_cell
            pbe_pow_cell u_cell (
                .aclk    (aclk),
                .en      (adv),
                .exp_bit (nexp[g]),
                .p_in    (p_w[g]),
                .base_in (b_w[g]),
                .p_out   (p_w[g+1]),
                .base_out(b_w[g+1])
            );
        end
    endgenerate

    logic [pbe_pkg::OUT_W-1:0] refl [3];
    logic [pbe_pkg::OUT_W-1:0] out_reg [3];
    generate
        for (g = 0; g < 3; g++) begin : g_ch
            pbe_channel #(.EXP_BITS(EXP_BITS)) u_ch (
                .aclk (aclk),
                .en   ({3{adv}}),
                .kd   (kd_reg[g]),
                .ks   (ks_reg[g]),
                .nexp (nexp),
                .p    (p_w[EXP_BITS]),
                .refl (refl[g])
            );
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) out_reg[i] <= refl[i];
        end
    end

    assign m_refl_red   = out_reg[0];
    assign m_refl_green = out_reg[1];
    assign m_refl_blue  = out_reg[2];

endmodule

[sim/phong_brdf_evaluate_unit_test.sv]
// Self-checking bench for phong_brdf_evaluate_unit: random shading samples against
// a bit-exact Phong BRDF predictor, with config phases and random handshake idling.
// Depends on pbe_pkg and the unit's RTL.
`timescale 1ns / 100ps

module phong_brdf_evaluate_unit_test;

    localparam int  DRAIN_CYCLES = pbe_pkg::EXP_BITS_DEF + 20;
    localparam int  CYCLE_LIMIT  = 400000;
    localparam int  PHASES       = 8;
    localparam int  PHASE_ITEMS  = 180;

    typedef struct packed {
        logic signed [pbe_pkg::VEC_W-1:0] lx, ly, lz, vx, vy, vz, nx, ny, nz;
    } sample_t;

    typedef struct packed {
        logic [pbe_pkg::OUT_W-1:0] r, g, b;
    } color_t;

    logic                           aclk;
    logic                           aresetn = 1'b0;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [pbe_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [pbe_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    logic                           s_valid = 1'b0;
    logic                           s_ready;
    logic signed [15:0]             s_light_x = '0, s_light_y = '0, s_light_z = '0;
    logic signed [15:0]             s_view_x = '0, s_view_y = '0, s_view_z = '0;
    logic signed [15:0]             s_surf_nx = '0, s_surf_ny = '0, s_surf_nz = '0;
    logic                           m_valid;
    logic                           m_ready = 1'b0;
    logic [pbe_pkg::OUT_W-1:0]      m_refl_red, m_refl_green, m_refl_blue;

    // shadow of the unit's registers
    logic [pbe_pkg::COL_W-1:0]  kd_r = '0, kd_g = '0, kd_b = '0;
    logic [pbe_pkg::COL_W-1:0]  ks_r = '0, ks_g = '0, ks_b = '0;
    logic [pbe_pkg::SHIN_W-1:0] shin = 10'd1;

    sample_t pending_q[$];
    color_t  color_q[$];
    sample_t cur;
    int      errors = 0;
    int      results_seen = 0;
    int      cyc = 0;
    int      tx_idle_pct = 0;
    int      rx_idle_pct = 0;
    logic    rx_hold = 1'b0;

    phong_brdf_evaluate_unit u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_light_x(s_light_x), .s_light_y(s_light_y), .s_light_z(s_light_z),
        .s_view_x(s_view_x), .s_view_y(s_view_y), .s_view_z(s_view_z),
        .s_surf_nx(s_surf_nx), .s_surf_ny(s_surf_ny), .s_surf_nz(s_surf_nz),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_refl_red(m_refl_red), .m_refl_green(m_refl_green), .m_refl_blue(m_refl_blue)
    );

    always begin
        aclk = 1'b0; #2;
        aclk = 1'b1; #2;
    end

    function automatic longint unsigned shade(longint unsigned kd, longint unsigned ks,
                                              longint unsigned nexp, longint unsigned p);
        longint unsigned t, sum, r;
        t   = ks * (nexp + 2) * p;
        sum = ((t + 32768) >> 16) * longint'(pbe_pkg::INV_2PI_Q32)
              + kd * longint'(pbe_pkg::INV_PI_Q32);
        r   = (sum + 64'h8000_0000) >> 32;
        return (r > longint'(pbe_pkg::OUT_MAX)) ? longint'(pbe_pkg::OUT_MAX) : r;
    endfunction

    function automatic color_t brdf_color(sample_t s);
        longint a, d, e, d14, c42;
        longint unsigned c, p, base, nexp;
        color_t res;
        a = longint'(s.lx) * s.vx + longint'(s.ly) * s.vy + longint'(s.lz) * s.vz;
        d = longint'(s.lx) * s.nx + longint'(s.ly) * s.ny + longint'(s.lz) * s.nz;
        e = longint'(s.nx) * s.vx + longint'(s.ny) * s.vy + longint'(s.nz) * s.vz;
        d14 = (d + 8192) >>> 14;
        c42 = a * 16384 - 2 * d14 * e;
        if (c42 <= 0) begin
            c = 0;
        end else begin
            c = (longint'(c42) + (64'd1 << 25)) >> 26;
            if (c > 65536) c = 65536;
        end
        nexp = shin & ((1 << pbe_pkg::EXP_BITS_DEF) - 1);
        p    = 65536;
        base = c;
        for (int i = 0; i < pbe_pkg::EXP_BITS_DEF; i++) begin
            if ((nexp >> i) & 1) p = (p * base + 32768) >> 16;
            base = (base * base + 32768) >> 16;
        end
        res.r = pbe_pkg::OUT_W'(shade(kd_r, ks_r, nexp, p));
        res.g = pbe_pkg::OUT_W'(shade(kd_g, ks_g, nexp, p));
        res.b = pbe_pkg::OUT_W'(shade(kd_b, ks_b, nexp, p));
        return res;
    endfunction

    task automatic report(string what, longint got, longint want);
        $display("mismatch at cycle %0d: %s got %0d want %0d", cyc, what, got, want);
        errors++;
    endtask

    // sender
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) color_q.push_back(brdf_color(cur));
            if (!s_valid || s_ready) begin
                if (pending_q.size() > 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
                    cur = pending_q.pop_front();
                    s_light_x <= cur.lx; s_light_y <= cur.ly; s_light_z <= cur.lz;
                    s_view_x  <= cur.vx; s_view_y  <= cur.vy; s_view_z  <= cur.vz;
                    s_surf_nx <= cur.nx; s_surf_ny <= cur.ny; s_surf_nz <= cur.nz;
                    s_valid   <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // receiver and checker
    always @(posedge aclk) begin
        color_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (color_q.size() == 0) begin
                    report("unexpected result", m_refl_red, -1);
                end else begin
                    want = color_q.pop_front();
                    if (m_refl_red !== want.r)   report("refl_red", m_refl_red, want.r);
                    if (m_refl_green !== want.g) report("refl_green", m_refl_green, want.g);
                    if (m_refl_blue !== want.b)  report("refl_blue", m_refl_blue, want.b);
                end
            end
            m_ready <= !rx_hold && ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    always @(posedge aclk) begin
        cyc++;
        if (cyc > CYCLE_LIMIT) begin
            $display("timeout with %0d results outstanding", color_q.size());
            $display("phong_brdf_evaluate_unit_test NOT OK");
            $finish;
        end
    end

    task automatic cfg_write(pbe_pkg::cfg_reg_t idx, logic [pbe_pkg::CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            pbe_pkg::REG_KD_R: kd_r = val;
            pbe_pkg::REG_KD_G: kd_g = val;
            pbe_pkg::REG_KD_B: kd_b = val;
            pbe_pkg::REG_KS_R: ks_r = val;
            pbe_pkg::REG_KS_G: ks_g = val;
            pbe_pkg::REG_KS_B: ks_b = val;
            pbe_pkg::REG_SHIN: shin = val[pbe_pkg::SHIN_W-1:0];
            default: ;
        endcase
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        while (pending_q.size() > 0 || s_valid || color_q.size() > 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    function automatic logic signed [15:0] q14(real v);
        int q;
        q = $rtoi(v * 16384.0 + (v < 0 ? -0.5 : 0.5));
        if (q > 16384) q = 16384;
        if (q < -16384) q = -16384;
        return 16'(q);
    endfunction

    function automatic real rnd();
        return ($itor($urandom_range(0, 20000)) - 10000.0) / 10000.0;
    endfunction

    task automatic unit_vec(output real x, output real y, output real z);
        real len;
        do begin
            x = rnd(); y = rnd(); z = rnd();
            len = $sqrt(x * x + y * y + z * z);
        end while (len < 0.05 || len > 1.0);
        x = x / len; y = y / len; z = z / len;
    endtask

    function automatic logic signed [15:0] raw_comp();
        return 16'($urandom_range(0, 32768) - 16384);
    endfunction

    task automatic push_random();
        sample_t s;
        real lx, ly, lz, vx, vy, vz, nx, ny, nz, dn;
        int kind;
        kind = $urandom_range(0, 9);
        unit_vec(lx, ly, lz);
        unit_vec(nx, ny, nz);
        unit_vec(vx, vy, vz);
        if (kind < 4) begin
            // view close to the mirror direction: high cosine, exercises the power chain
            dn = lx * nx + ly * ny + lz * nz;
            vx = lx - 2.0 * dn * nx + 0.05 * rnd();
            vy = ly - 2.0 * dn * ny + 0.05 * rnd();
            vz = lz - 2.0 * dn * nz + 0.05 * rnd();
            dn = $sqrt(vx * vx + vy * vy + vz * vz);
            if (dn > 0.01) begin vx = vx / dn; vy = vy / dn; vz = vz / dn; end
        end
        s = '{q14(lx), q14(ly), q14(lz), q14(vx), q14(vy), q14(vz), q14(nx), q14(ny), q14(nz)};
        if (kind >= 8) begin
            s = '{raw_comp(), raw_comp(), raw_comp(), raw_comp(), raw_comp(), raw_comp(),
                  raw_comp(), raw_comp(), raw_comp()};
        end
        pending_q.push_back(s);
    endtask

    function automatic logic [pbe_pkg::CFG_DATA_W-1:0] rnd_col();
        return pbe_pkg::CFG_DATA_W'($urandom_range(0, 65536));
    endfunction

    initial begin
        logic [pbe_pkg::CFG_DATA_W-1:0] kd[3], ks[3];
        logic [pbe_pkg::SHIN_W-1:0]     sh;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // directed samples under the reset settings
        pending_q.push_back('{0, 0, 0, 0, 0, 0, 0, 0, 0});
        pending_q.push_back('{16384, 16384, 16384, 16384, 16384, 16384, 16384, 16384, 16384});
        pending_q.push_back('{-16384, -16384, -16384, -16384, -16384, -16384,
                              -16384, -16384, -16384});
        pending_q.push_back('{0, 0, -16384, 0, 0, 16384, 0, 0, 16384});  // exact mirror
        pending_q.push_back('{0, 0, -16384, 0, 0, -16384, 0, 0, 16384}); // negative cosine
        pending_q.push_back('{16384, 0, 0, 16384, 0, 0, 0, 16384, 0});   // grazing
        pending_q.push_back('{16384, 16384, 0, 16384, 16384, 0, 0, 0, 16384}); // cos above one
        pending_q.push_back('{-16384, 16384, -16384, 16384, -16384, 16384,
                              16384, -16384, 16384});
        pending_q.push_back('{11585, 0, -11585, 11585, 0, 11585, 0, 0, 16384});
        pending_q.push_back('{-1, 1, -1, 1, -1, 1, 0, 0, 1});
        for (int i = 0; i < 10; i++) push_random();
        wait_idle();

        for (int k = 0; k < PHASES; k++) begin
            for (int c = 0; c < 3; c++) begin kd[c] = rnd_col(); ks[c] = rnd_col(); end
            sh = pbe_pkg::SHIN_W'($urandom_range(0, 1023));
            case (k)
                0: begin kd = '{65536, 65536, 65536}; ks = '{65536, 65536, 65536}; sh = 1023; end
                1: begin kd = '{0, 0, 0}; ks = '{0, 0, 0}; sh = 0; end
                2: sh = 0;
                3: sh = pbe_pkg::SHIN_W'($urandom_range(0, 12));
                4: begin kd = '{0, 0, 0}; ks = '{65536, 65536, 65536}; sh = 1; end
                6: sh = 2;
                7: sh = 1023;
                default: ;
            endcase
            cfg_write(pbe_pkg::REG_KD_R, kd[0]);
            cfg_write(pbe_pkg::REG_KD_G, kd[1]);
            cfg_write(pbe_pkg::REG_KD_B, kd[2]);
            cfg_write(pbe_pkg::REG_KS_R, ks[0]);
            cfg_write(pbe_pkg::REG_KS_G, ks[1]);
            cfg_write(pbe_pkg::REG_KS_B, ks[2]);
            cfg_write(pbe_pkg::REG_SHIN, {7'd0, sh});
            cfg_write(pbe_pkg::REG_NONE, rnd_col());  // unmapped, must be ignored

            case (k * 3 / PHASES)
                0: begin tx_idle_pct = 37; rx_idle_pct = 54; end
                1: begin tx_idle_pct = 54; rx_idle_pct = 37; end
                default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
            endcase
            for (int i = 0; i < PHASE_ITEMS; i++) push_random();
            if (k == 6) begin
                // long receiver stall while requests keep coming, backs up the pipe
                repeat (40) @(posedge aclk);
                rx_hold <= 1'b1;
                repeat (200) @(posedge aclk);
                rx_hold <= 1'b0;
            end
            wait_idle();
        end

        $display("ran %0d results over %0d register settings, idling on both sides",
                 results_seen, PHASES + 1);
        if (errors == 0) begin
            $display("phong_brdf_evaluate_unit_test OK");
        end else begin
            $display("%0d mismatches", errors);
            $display("phong_brdf_evaluate_unit_test NOT OK");
        end
        $finish;
    end

endmodule

[files.f]
hdl/pbe_pkg.sv
hdl/pbe_pow_cell.sv
hdl/pbe_channel.sv
hdl/phong_brdf_evaluate_unit.sv
sim/phong_brdf_evaluate_unit_test.sv
